FILE: rtl/eor_pkg.sv
// ----------------------------------------------------------------------------
// eor_pkg: shared types and constants of the ellipse outline rasterizer
// Command and status bundles between controller and datapath, operand and
// decision-update codes, and the fixed limits of the block.
// ----------------------------------------------------------------------------
package eor_pkg;

  // fixed limits
  localparam int MAX_RADIUS    = 1023;
  localparam int MAX_MASK_SIDE = 1024;

  // field widths
  localparam int CoordW  = 12;
  localparam int RadiusW = 10;
  localparam int MaskW   = 11;
  localparam int PixW    = 10;

  // mask register reset value
  localparam logic [MaskW-1:0] MASK_RESET = 11'd256;

  // register indexes
  localparam logic REG_MASK_WIDTH  = 1'b0;
  localparam logic REG_MASK_HEIGHT = 1'b1;

  // request kinds
  localparam logic KIND_START = 1'b0;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_AA      = 3'd0,
    MUL_BB      = 3'd1,
    MUL_RX2_B   = 3'd2,
    MUL_TX_TX   = 3'd3,
    MUL_TY_TY   = 3'd4,
    MUL_RY2_T1  = 3'd5,
    MUL_RX2_T2  = 3'd6,
    MUL_RX2_RY2 = 3'd7
  } mul_sel_t;

  // decision register update
  typedef enum logic [2:0] {
    DEC_HOLD    = 3'd0,
    DEC_R1_INIT = 3'd1,
    DEC_LOAD    = 3'd2,
    DEC_ADD4    = 3'd3,
    DEC_SUB4    = 3'd4,
    DEC_TRUNC   = 3'd5,
    DEC_STEP_A  = 3'd6,
    DEC_STEP_B  = 3'd7
  } dec_op_t;

  // controller to datapath
  typedef struct packed {
    logic      load_start;
    mul_sel_t  mul_sel;
    logic      ld_rx2;
    logic      ld_ry2;
    logic      ld_py_init;
    logic      ld_t1;
    logic      ld_t2;
    dec_op_t   dec_op;
    logic      region2;
    logic      upd;
    logic      out_load;
    logic      out_pixel;
    logic [1:0] out_idx;
    logic      out_last;
    logic      out_done;
  } eor_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic       slope_lt;
    logic       y_zero;
    logic       y_neg;
    logic       take_b;
    logic [3:0] in_mask;
  } eor_sts_t;

endpackage

FILE: rtl/eor_regs.sv
// ----------------------------------------------------------------------------
// eor_regs: configuration registers
// Mask width and height, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module eor_regs
  import eor_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [MaskW-1:0] mask_width,
  output logic [MaskW-1:0] mask_height
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width  <= MASK_RESET;
      mask_height <= MASK_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MASK_WIDTH:  mask_width  <= pwdata[MaskW-1:0];
        REG_MASK_HEIGHT: mask_height <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_MASK_WIDTH:  prdata = {{(32-MaskW){1'b0}}, mask_width};
      REG_MASK_HEIGHT: prdata = {{(32-MaskW){1'b0}}, mask_height};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/eor_ctrl.sv
// ----------------------------------------------------------------------------
// eor_ctrl: rasterizer sequencer
// One-hot state machine that runs the setup multiplies, walks the pixels of
// one pass into the output register and orders the term updates.
// ----------------------------------------------------------------------------
module eor_ctrl
  import eor_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     kind,
  input  eor_sts_t sts,
  output eor_cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_ST1  = 19'h00002,
    S_ST2  = 19'h00004,
    S_ST3  = 19'h00008,
    S_ST4  = 19'h00010,
    S_ST5  = 19'h00020,
    S_STAT = 19'h00040,
    S_R2A  = 19'h00080,
    S_R2B  = 19'h00100,
    S_R2C  = 19'h00200,
    S_R2D  = 19'h00400,
    S_R2E  = 19'h00800,
    S_R2F  = 19'h01000,
    S_R2G  = 19'h02000,
    S_LOAD = 19'h04000,
    S_EMIT = 19'h08000,
    S_UPD  = 19'h10000,
    S_DECA = 19'h20000,
    S_DECB = 19'h40000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ONE  = 3'b010,
    PH_TWO  = 3'b100
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [3:0] pend, pend_next;
  logic [3:0] pend_rest;
  logic [1:0] low_idx;
  logic       stat_done, stat_done_next;
  logic       pass_done;

  // lowest pending pixel of the pass
  always_comb begin
    if (pend[0])      low_idx = 2'd0;
    else if (pend[1]) low_idx = 2'd1;
    else if (pend[2]) low_idx = 2'd2;
    else              low_idx = 2'd3;
  end

  assign pend_rest = pend & (pend - 4'd1);
  assign pass_done = (phase == PH_TWO) && sts.y_zero;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      pend      <= 4'd0;
      stat_done <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      pend      <= pend_next;
      stat_done <= stat_done_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    pend_next      = pend;
    stat_done_next = stat_done;
    cmd            = '0;
    cmd.region2    = (phase == PH_TWO);
    in_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_START) begin
            cmd.load_start = 1'b1;
            state_next     = S_ST1;
          end else begin
            unique case (phase)
              PH_ONE:  state_next = sts.slope_lt ? S_LOAD : S_R2A;
              PH_TWO:  state_next = S_LOAD;
              default: begin
                stat_done_next = 1'b1;
                state_next     = S_STAT;
              end
            endcase
          end
        end
      end
      // start setup: squares, slope term and region-one decision
      S_ST1: begin
        cmd.mul_sel = MUL_AA;
        state_next  = S_ST2;
      end
      S_ST2: begin
        cmd.ld_rx2  = 1'b1;
        cmd.mul_sel = MUL_BB;
        state_next  = S_ST3;
      end
      S_ST3: begin
        cmd.ld_ry2  = 1'b1;
        cmd.mul_sel = MUL_RX2_B;
        state_next  = S_ST4;
      end
      S_ST4: begin
        cmd.ld_py_init = 1'b1;
        cmd.dec_op     = DEC_R1_INIT;
        state_next     = S_ST5;
      end
      S_ST5: begin
        cmd.dec_op     = DEC_TRUNC;
        phase_next     = PH_ONE;
        stat_done_next = 1'b0;
        state_next     = S_STAT;
      end
      // status-only result
      S_STAT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_done = stat_done;
          state_next   = S_IDLE;
        end
      end
      // region-two decision setup
      S_R2A: begin
        cmd.mul_sel = MUL_TX_TX;
        state_next  = S_R2B;
      end
      S_R2B: begin
        cmd.ld_t1   = 1'b1;
        cmd.mul_sel = MUL_TY_TY;
        state_next  = S_R2C;
      end
      S_R2C: begin
        cmd.ld_t2   = 1'b1;
        cmd.mul_sel = MUL_RY2_T1;
        state_next  = S_R2D;
      end
      S_R2D: begin
        cmd.dec_op  = DEC_LOAD;
        cmd.mul_sel = MUL_RX2_T2;
        state_next  = S_R2E;
      end
      S_R2E: begin
        cmd.dec_op  = DEC_ADD4;
        cmd.mul_sel = MUL_RX2_RY2;
        state_next  = S_R2F;
      end
      S_R2F: begin
        cmd.dec_op = DEC_SUB4;
        state_next = S_R2G;
      end
      S_R2G: begin
        cmd.dec_op = DEC_TRUNC;
        phase_next = PH_TWO;
        state_next = S_LOAD;
      end
      // one pass: capture which pixels fall in the mask, then send them
      S_LOAD: begin
        pend_next  = sts.in_mask;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_done = pass_done;
          if (pend == 4'd0) begin
            cmd.out_last = 1'b1;
            state_next   = S_UPD;
          end else begin
            cmd.out_pixel = 1'b1;
            cmd.out_idx   = low_idx;
            cmd.out_last  = (pend_rest == 4'd0);
            pend_next     = pend_rest;
            if (pend_rest == 4'd0) state_next = S_UPD;
          end
        end
      end
      // term updates after the pass
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DECA;
      end
      S_DECA: begin
        cmd.dec_op = DEC_STEP_A;
        if (sts.take_b) begin
          state_next = S_DECB;
        end else begin
          if ((phase == PH_TWO) && sts.y_neg) phase_next = PH_IDLE;
          state_next = S_IDLE;
        end
      end
      S_DECB: begin
        cmd.dec_op = DEC_STEP_B;
        if ((phase == PH_TWO) && sts.y_neg) phase_next = PH_IDLE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // checks
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_two_has_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && phase == PH_TWO) |-> !sts.y_neg)
    else $error("region two left open below row zero");

  a_pend_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> ((pend & ~$past(pend)) == 4'd0))
    else $error("pending pixel set grew during emission");

  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_START) |=> (state == S_ST1))
    else $error("start request did not begin setup");

  a_decb_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECB) |-> ($past(state) == S_DECA))
    else $error("second decision update out of order");

endmodule

FILE: rtl/eor_dp.sv
// ----------------------------------------------------------------------------
// eor_dp: rasterizer datapath
// Center, offsets, squared radii, slope terms and decision value, one shared
// registered multiplier, mask test of the four pixels and the result register.
// ----------------------------------------------------------------------------
module eor_dp
  import eor_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  eor_cmd_t                  cmd,
  output eor_sts_t                  sts,
  input  logic signed [CoordW-1:0]  center_x,
  input  logic signed [CoordW-1:0]  center_y,
  input  logic [RadiusW-1:0]        radius_x,
  input  logic [RadiusW-1:0]        radius_y,
  input  logic [MaskW-1:0]          mask_width,
  input  logic [MaskW-1:0]          mask_height,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PixW-1:0]           pixel_row,
  output logic [PixW-1:0]           pixel_col,
  output logic                      pixel_valid,
  output logic                      last_of_step,
  output logic                      drawing_done
);

  localparam logic [RadiusW-1:0] RadiusLimit =
    (MAX_RADIUS > 1023) ? 10'd1023 : 10'(MAX_RADIUS);
  localparam logic [MaskW-1:0] SideLimit =
    (MAX_MASK_SIDE > 1024) ? 11'd1024 : 11'(MAX_MASK_SIDE);

  logic signed [11:0] cx, cy;
  logic [9:0]         ra, rb;
  logic [10:0]        x;
  logic signed [11:0] y;
  logic [19:0]        rx2, ry2;
  logic signed [31:0] px, py;
  logic signed [47:0] d, d_next;
  logic [21:0]        t1;
  logic [19:0]        t2;
  logic [47:0]        prod;
  logic               take_b;

  logic [23:0]        op_a, op_b;
  logic [11:0]        tx;
  logic [9:0]         ty_abs;
  logic signed [31:0] px_step, py_step;
  logic signed [47:0] d_trunc, d_q, prod4, ry2_ext, rx2_ext, px_ext, py_ext;
  logic [9:0]         ra_sat, rb_sat;

  logic [MaskW-1:0]   side_w, side_h;
  logic signed [13:0] row_p, row_m, col_p, col_m;
  logic signed [13:0] row_k [4];
  logic signed [13:0] col_k [4];
  logic [3:0]         in_mask;

  // radius saturation on start
  assign ra_sat = (radius_x > RadiusLimit) ? RadiusLimit : radius_x;
  assign rb_sat = (radius_y > RadiusLimit) ? RadiusLimit : radius_y;

  // region-two operands
  assign tx     = {x, 1'b1};
  assign ty_abs = (y == 12'sd0) ? 10'd1 : 10'(y - 12'sd1);

  // shared multiplier operand mux
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AA:      begin op_a = {14'd0, ra};  op_b = {14'd0, ra};     end
      MUL_BB:      begin op_a = {14'd0, rb};  op_b = {14'd0, rb};     end
      MUL_RX2_B:   begin op_a = {4'd0, rx2};  op_b = {14'd0, rb};     end
      MUL_TX_TX:   begin op_a = {12'd0, tx};  op_b = {12'd0, tx};     end
      MUL_TY_TY:   begin op_a = {14'd0, ty_abs}; op_b = {14'd0, ty_abs}; end
      MUL_RY2_T1:  begin op_a = {4'd0, ry2};  op_b = {2'd0, t1};      end
      MUL_RX2_T2:  begin op_a = {4'd0, rx2};  op_b = {4'd0, t2};      end
      MUL_RX2_RY2: begin op_a = {4'd0, rx2};  op_b = {4'd0, ry2};     end
      default:     begin op_a = 24'd0;        op_b = 24'd0;           end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // slope term steps
  assign px_step = px + $signed({11'd0, ry2, 1'b0});
  assign py_step = py - $signed({11'd0, rx2, 1'b0});

  // decision update terms
  assign prod4   = $signed({prod[45:0], 2'b00});
  assign ry2_ext = $signed({28'd0, ry2});
  assign rx2_ext = $signed({28'd0, rx2});
  assign px_ext  = {{16{px[31]}}, px};
  assign py_ext  = {{16{py[31]}}, py};
  assign d_q     = d >>> 2;
  assign d_trunc = (d[47] && (d[1:0] != 2'b00)) ? (d_q + 48'sd1) : d_q;

  always_comb begin
    case (cmd.dec_op)
      DEC_R1_INIT: d_next = $signed({26'd0, ry2, 2'b00}) + rx2_ext - prod4;
      DEC_LOAD:    d_next = $signed(prod);
      DEC_ADD4:    d_next = d + prod4;
      DEC_SUB4:    d_next = d - prod4;
      DEC_TRUNC:   d_next = d_trunc;
      DEC_STEP_A:  d_next = cmd.region2 ? (d + rx2_ext - py_ext) : (d + ry2_ext + px_ext);
      DEC_STEP_B:  d_next = cmd.region2 ? (d + px_ext) : (d - py_ext);
      default:     d_next = d;
    endcase
  end

  // ellipse state
  always_ff @(posedge clk) begin
    if (rst) begin
      cx     <= '0;
      cy     <= '0;
      ra     <= '0;
      rb     <= '0;
      x      <= '0;
      y      <= '0;
      rx2    <= '0;
      ry2    <= '0;
      px     <= '0;
      py     <= '0;
      d      <= '0;
      take_b <= 1'b0;
    end else begin
      d <= d_next;
      if (cmd.load_start) begin
        cx <= center_x;
        cy <= center_y;
        ra <= ra_sat;
        rb <= rb_sat;
        x  <= '0;
        y  <= $signed({2'd0, rb_sat});
        px <= '0;
      end
      if (cmd.ld_rx2)     rx2 <= prod[19:0];
      if (cmd.ld_ry2)     ry2 <= prod[19:0];
      if (cmd.ld_py_init) py  <= $signed({prod[30:0], 1'b0});
      if (cmd.upd) begin
        if (cmd.region2) begin
          // row always steps, column when the midpoint is inside
          y      <= y - 12'sd1;
          py     <= py_step;
          take_b <= (d <= 48'sd0);
          if (d <= 48'sd0) begin
            x  <= x + 11'd1;
            px <= px_step;
          end
        end else begin
          // column always steps, row when the midpoint is outside
          x      <= x + 11'd1;
          px     <= px_step;
          take_b <= !d[47];
          if (!d[47]) begin
            y  <= y - 12'sd1;
            py <= py_step;
          end
        end
      end
    end
  end

  // region-two product scratch
  always_ff @(posedge clk) begin
    if (cmd.ld_t1) t1 <= prod[21:0];
    if (cmd.ld_t2) t2 <= prod[19:0];
  end

  // symmetric pixels and mask test
  assign side_w = (mask_width  > SideLimit) ? SideLimit : mask_width;
  assign side_h = (mask_height > SideLimit) ? SideLimit : mask_height;
  assign row_p  = {{2{cy[11]}}, cy} + {{2{y[11]}}, y};
  assign row_m  = {{2{cy[11]}}, cy} - {{2{y[11]}}, y};
  assign col_p  = {{2{cx[11]}}, cx} + $signed({3'd0, x});
  assign col_m  = {{2{cx[11]}}, cx} - $signed({3'd0, x});

  always_comb begin
    row_k[0] = row_p; col_k[0] = col_p;
    row_k[1] = row_p; col_k[1] = col_m;
    row_k[2] = row_m; col_k[2] = col_p;
    row_k[3] = row_m; col_k[3] = col_m;
    for (int k = 0; k < 4; k++) begin
      in_mask[k] = !row_k[k][13] && (row_k[k] < $signed({3'd0, side_h}))
                && !col_k[k][13] && (col_k[k] < $signed({3'd0, side_w}));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_row    <= cmd.out_pixel ? row_k[cmd.out_idx][PixW-1:0] : '0;
      pixel_col    <= cmd.out_pixel ? col_k[cmd.out_idx][PixW-1:0] : '0;
      pixel_valid  <= cmd.out_pixel;
      last_of_step <= cmd.out_last;
      drawing_done <= cmd.out_done;
    end
  end

  // status to the sequencer
  assign sts.out_free = !out_valid || out_ready;
  assign sts.slope_lt = (px < py);
  assign sts.y_zero   = (y == 12'sd0);
  assign sts.y_neg    = y[11];
  assign sts.take_b   = take_b;
  assign sts.in_mask  = in_mask;

endmodule

FILE: rtl/ellipse_outline_rasterizer.sv
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer: midpoint ellipse outline generator
// Start requests set up an ellipse; each step request runs one pass of the
// midpoint loop and sends the symmetric pixels that fall inside the mask.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   cfg      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//   in       | in_valid/in_ready    | kind, center_x, center_y, radius_x/_y
//   out      | out_valid/out_ready  | pixel_row, pixel_col, pixel_valid,
//            |                      | last_of_step, drawing_done
//
// start request: setup multiplies on the shared multiplier, then a status result
// step request: capture, one result per pixel through the output register (or
//   a status-only result when none is in the mask), slope update and one or two
//   decision updates; switching to region two adds multiplies on the same
//   multiplier; a step with no ellipse in progress sends only a status result
// reset is synchronous; the sequencer returns to idle and the ellipse state clears to an empty ellipse
// a stalled output holds the sequencer; in_ready is high only between requests
//
module ellipse_outline_rasterizer
  import eor_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic signed [CoordW-1:0]  center_x,
  input  logic signed [CoordW-1:0]  center_y,
  input  logic [RadiusW-1:0]        radius_x,
  input  logic [RadiusW-1:0]        radius_y,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PixW-1:0]           pixel_row,
  output logic [PixW-1:0]           pixel_col,
  output logic                      pixel_valid,
  output logic                      last_of_step,
  output logic                      drawing_done
);

  logic [MaskW-1:0] mask_width;
  logic [MaskW-1:0] mask_height;
  eor_cmd_t         cmd;
  eor_sts_t         sts;

  // configuration registers
  eor_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mask_width  (mask_width),
    .mask_height (mask_height)
  );

  // sequencer
  eor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  eor_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .mask_width   (mask_width),
    .mask_height  (mask_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .pixel_valid  (pixel_valid),
    .last_of_step (last_of_step),
    .drawing_done (drawing_done)
  );

endmodule
